FILE: rtl/core/wrm_pkg.sv
// Shared types and constants for the windowed rate and average meter.
package wrm_pkg;

    localparam int DEPTH     = 1024;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int STAMP_W   = 32;
    localparam int VALUE_W   = 32;
    localparam int WIN_W     = 24;
    localparam int RES_W     = 32;
    localparam int RATE_W    = 28;
    localparam int SUM_W     = VALUE_W + CNT_W;
    localparam int BYTE_SHIFT = 3;
    localparam int DVD_W     = SUM_W + BYTE_SHIFT;
    localparam int BIT_W     = $clog2(DVD_W);
    localparam int CFG_W     = WIN_W;
    localparam int CFG_IDX_W = 1;

    localparam int unsigned MS_PER_S   = 1000;
    localparam int unsigned Q8_ONE     = 256;
    localparam int unsigned RATE_SCALE = MS_PER_S * Q8_ONE;
    localparam int RS_W   = $clog2(RATE_SCALE + 1);
    localparam int PROD_W = CNT_W + RS_W;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(5000);
    localparam logic             MODE_RESET   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b1;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIV_RES,
        ST_DIV_RATE
    } state_t;

    typedef struct packed {
        logic               cmd;
        logic [STAMP_W-1:0] now_ms;
        logic [VALUE_W-1:0] sample_value;
    } item_t;

    typedef struct packed {
        logic [RES_W-1:0]  window_result;
        logic [CNT_W-1:0]  event_count;
        logic [RATE_W-1:0] event_rate_q8;
    } result_t;

endpackage

FILE: rtl/core/windowed_rate_and_average_meter_core.sv
// Windowed rate and average meter: ring store, backward walk and bit-serial divider.
//
// Usage: a word on item is taken when start is high and busy is low.
// A record word (cmd low) writes stamp and value into the ring and produces
// nothing; busy stays low, so records can arrive every cycle.
// A query word (cmd high) raises busy and walks back from the newest entry,
// one ring read per cycle, while entries are filled and younger than
// window_ms. The RAM read is registered, so one read is already issued
// past the entry that ends the walk. If entries were found, a restoring
// divider producing one quotient bit per cycle runs twice (result, then
// event rate). The result word then appears on result, and done is high
// for exactly one cycle; busy has already dropped in that cycle. When
// nothing lies in the window, the divider is skipped and a zero result is
// registered with done at the end of the walk. The receiver cannot stall;
// done is a strobe. Reset empties the ring through a fill count, so no
// clearing pass is needed; window_ms returns to 5000 and rate_mode to 1.
// Configuration must be written through cfg_we/cfg_index/cfg_data while the
// block is idle; the block itself does not enforce this.
module windowed_rate_and_average_meter_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  wrm_pkg::item_t                    item,
    output logic                              done,
    output wrm_pkg::result_t                  result,
    input  logic                              cfg_we,
    input  logic [wrm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wrm_pkg::CFG_W-1:0]         cfg_data
);

    import wrm_pkg::*;

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     wp_reg, wp_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [PTR_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic                 stop_reg, stop_next;
    logic                 pend_reg, pend_next;
    logic                 done_reg, done_next;
    logic [WIN_W-1:0]     window_reg;
    logic                 mode_reg;

    logic [STAMP_W-1:0]   now_reg, now_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [WIN_W-1:0]     rem_reg, rem_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [WIN_W-1:0]     dsr_reg, dsr_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [RES_W-1:0]     res_val_reg, res_val_next;
    result_t              result_reg, result_next;

    logic                 accept;
    logic                 issue;
    logic                 walk_end;
    logic                 ram_we;
    logic [PTR_W-1:0]     ram_addr;
    logic [STAMP_W-1:0]   stamp_rd;
    logic [VALUE_W-1:0]   value_rd;
    logic [STAMP_W-1:0]   age;
    logic                 hit;
    logic [WIN_W:0]       trial;
    logic [WIN_W:0]       diff;
    logic                 ge;
    logic [DVD_W-1:0]     quo_step;
    logic [WIN_W-1:0]     rem_step;
    logic                 div_last;
    logic [PROD_W-1:0]    rate_prod;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign ram_we   = accept && (item.cmd == CMD_RECORD);
    assign ram_addr = (state_reg == ST_IDLE) ? wp_reg : pos_reg;

    wrm_ram #(.WIDTH(STAMP_W), .DEPTH(DEPTH)) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (item.now_ms),
        .rdata (stamp_rd)
    );

    wrm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (item.sample_value),
        .rdata (value_rd)
    );

    // A slot is filled when it lies within fill_reg entries behind the write pointer.
    assign issue    = (state_reg == ST_WALK) && (n_reg != fill_reg) && !stop_reg;
    assign walk_end = (state_reg == ST_WALK) && !issue && !pend_reg;
    assign age      = now_reg - stamp_rd;
    assign hit      = pend_reg && !stop_reg && (age < STAMP_W'(window_reg));

    // One restoring division step per cycle.
    assign trial    = {rem_reg, quo_reg[DVD_W-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign ge       = (trial >= {1'b0, dsr_reg});
    assign rem_step = ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
    assign quo_step = {quo_reg[DVD_W-2:0], ge};
    assign div_last = (bit_reg == BIT_W'(DVD_W - 1));

    assign rate_prod = PROD_W'(count_reg) * PROD_W'(RATE_SCALE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.cmd == CMD_QUERY))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_end)
                begin
                    state_next = (count_reg == '0) ? ST_IDLE : ST_DIV_RES;
                end
            end
            ST_DIV_RES:
            begin
                if (div_last)
                begin
                    state_next = ST_DIV_RATE;
                end
            end
            ST_DIV_RATE:
            begin
                if (div_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wp_next      = wp_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        n_next       = n_reg;
        stop_next    = stop_reg;
        pend_next    = 1'b0;
        done_next    = 1'b0;
        now_next     = now_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dsr_next     = dsr_reg;
        bit_next     = bit_reg;
        res_val_next = res_val_reg;
        result_next  = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.cmd == CMD_RECORD)
                    begin
                        wp_next = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                        if (fill_reg != CNT_W'(DEPTH))
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        now_next   = item.now_ms;
                        pos_next   = (wp_reg == '0) ? PTR_W'(DEPTH - 1) : wp_reg - 1'b1;
                        n_next     = '0;
                        stop_next  = 1'b0;
                        sum_next   = '0;
                        count_next = '0;
                    end
                end
            end
            ST_WALK:
            begin
                pend_next = issue;
                if (issue)
                begin
                    pos_next = (pos_reg == '0) ? PTR_W'(DEPTH - 1) : pos_reg - 1'b1;
                    n_next   = n_reg + 1'b1;
                end
                if (hit)
                begin
                    sum_next   = sum_reg + SUM_W'(value_rd);
                    count_next = count_reg + 1'b1;
                end
                else if (pend_reg && !stop_reg)
                begin
                    stop_next = 1'b1;
                end
                if (walk_end)
                begin
                    if (count_reg == '0)
                    begin
                        result_next = '0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        quo_next = mode_reg ? {sum_reg, BYTE_SHIFT'(0)} : DVD_W'(sum_reg);
                        dsr_next = mode_reg ? window_reg : WIN_W'(count_reg);
                        rem_next = '0;
                        bit_next = '0;
                    end
                end
            end
            ST_DIV_RES:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                bit_next = bit_reg + 1'b1;
                if (div_last)
                begin
                    res_val_next = (|quo_step[DVD_W-1:RES_W]) ? '1 : quo_step[RES_W-1:0];
                    quo_next     = DVD_W'(rate_prod);
                    dsr_next     = window_reg;
                    rem_next     = '0;
                    bit_next     = '0;
                end
            end
            ST_DIV_RATE:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                bit_next = bit_reg + 1'b1;
                if (div_last)
                begin
                    result_next.window_result = res_val_reg;
                    result_next.event_count   = count_reg;
                    result_next.event_rate_q8 = (|quo_step[DVD_W-1:RATE_W]) ? '1
                                                : quo_step[RATE_W-1:0];
                    done_next = 1'b1;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wp_reg     <= '0;
            fill_reg   <= '0;
            pos_reg    <= '0;
            n_reg      <= '0;
            stop_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            bit_reg    <= '0;
            window_reg <= WINDOW_RESET;
            mode_reg   <= MODE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
            n_reg     <= n_next;
            stop_reg  <= stop_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            bit_reg   <= bit_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW: window_reg <= cfg_data[WIN_W-1:0];
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    default:    mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        sum_reg     <= sum_next;
        count_reg   <= count_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dsr_reg     <= dsr_next;
        res_val_reg <= res_val_next;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: rtl/core/wrm_ram.sv
// Generic single-port RAM with registered read data.
module wrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule
